/* design/bbv_pkg.sv */
// Shared types and constants for the bounding box volume and distance unit.
// Used by bbv_isqrt and bounding_box_volume_and_mindist; depends on nothing.
package bbv_pkg;

    localparam int DIMS     = 4;
    localparam int DIM_W    = (DIMS > 1) ? $clog2(DIMS) : 1;
    localparam int KIND_W   = 3;
    localparam int COORD_W  = 16;
    localparam int EXT_W    = 16;
    localparam int MUL_A_W  = 32;
    localparam int MUL_P_W  = MUL_A_W + EXT_W;
    localparam int VOL_W    = 63;
    localparam int DIST_W   = 18;
    localparam int SUM_W    = 2 * DIST_W;
    localparam int SQ_REM_W = DIST_W + 2;
    localparam int SQ_CNT_W = $clog2(DIST_W + 1);

    localparam logic [VOL_W-1:0] VOL_MAX = {VOL_W{1'b1}};

    typedef enum logic [KIND_W-1:0] {
        K_SET     = 3'd0,
        K_EXTEND  = 3'd1,
        K_ENLARGE = 3'd2,
        K_VOLUME  = 3'd3,
        K_DIST    = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_MUL_LO,
        S_MUL_HI,
        S_ACC,
        S_SQRT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_sqrt_stat;

endpackage

/* design/bbv_isqrt.sv */
// Bit-serial floor square root: one root bit per cycle, DIST_W root bits per run.
// Depends on bbv_pkg for widths and the status struct.
module bbv_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [bbv_pkg::SUM_W-1:0]     i_radicand,
    output logic [bbv_pkg::DIST_W-1:0]    o_root,
    output bbv_pkg::t_sqrt_stat           o_stat
);
    import bbv_pkg::*;

    logic [SUM_W-1:0]    r_x;
    logic [SQ_REM_W-1:0] r_rem;
    logic [DIST_W-1:0]   r_root;
    logic [SQ_CNT_W-1:0] r_cnt;
    logic                r_done;

    logic [SQ_REM_W+1:0] w_rem_sh;
    logic [SQ_REM_W+1:0] w_trial;
    logic [SQ_REM_W+1:0] w_diff;
    logic                w_ge;

    always_comb begin
        w_rem_sh = {r_rem, r_x[SUM_W-1 -: 2]};
        w_trial  = {2'b00, r_root, 2'b01};
        w_ge     = (w_rem_sh >= w_trial);
        w_diff   = w_rem_sh - w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= SQ_CNT_W'(DIST_W);
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == SQ_CNT_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_cnt != '0) begin
            r_x    <= {r_x[SUM_W-3:0], 2'b00};
            r_rem  <= w_ge ? w_diff[SQ_REM_W-1:0] : w_rem_sh[SQ_REM_W-1:0];
            r_root <= {r_root[DIST_W-2:0], w_ge};
        end
    end

    assign o_root      = r_root;
    assign o_stat.busy = (r_cnt != '0);
    assign o_stat.done = r_done;

endmodule

/* design/bounding_box_volume_and_mindist.sv */
// Top level of the bounding box volume and point distance unit.
// Depends on bbv_pkg and bbv_isqrt.
//
//  channel   direction  handshake                   payload
//  --------  ---------  --------------------------  ----------------------------------
//  request   in         i_in_valid / o_in_stall     i_kind, i_low_coord, i_high_coord
//  result    out        o_out_valid / i_out_stall   o_volume, o_volume_saturated,
//                                                   o_distance
//
// Sequence: one request at a time. A volume-type request (set, extend, enlarged or
//   current volume) passes bounds read, compare, two halves of the 63x16 product
//   through one shared 32x16 multiplier, and accumulate. A distance request squares
//   its gap in a single multiply. The last request of a run adds the result
//   register, and for a distance run the bit-serial square root before it (18 root
//   bits, its done flag raised with the last).
// Reset: synchronous, active low; the bounds read as zero until written (one valid
//   bit per dimension), the run restarts at dimension 0 with a product of one.
// Stalls: a finished result waits in the output register; new requests are taken
//   meanwhile, and only a later result waits for that register to drain.
module bounding_box_volume_and_mindist (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [bbv_pkg::KIND_W-1:0]           i_kind,
    input  logic signed [bbv_pkg::COORD_W-1:0]   i_low_coord,
    input  logic signed [bbv_pkg::COORD_W-1:0]   i_high_coord,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [bbv_pkg::VOL_W-1:0]            o_volume,
    output logic                                 o_volume_saturated,
    output logic [bbv_pkg::DIST_W-1:0]           o_distance
);
    import bbv_pkg::*;

    // ---------------------------------------------------------------- state
    t_state                      r_state, n_state;
    logic [DIM_W-1:0]            r_dim;
    t_kind                       r_run_kind;
    logic signed [COORD_W-1:0]   r_lo, r_hi, r_pt;

    // bounds memory: {lower, upper} per dimension, valid bits give reset value
    logic [2*COORD_W-1:0]        r_bounds_mem [DIMS];
    logic [DIMS-1:0]             r_bounds_vld;
    logic [2*COORD_W-1:0]        r_rd_data;
    logic                        r_rd_vld;

    logic [EXT_W-1:0]            r_ext;
    logic                        r_zero_ext;
    logic [MUL_P_W-1:0]          r_p_lo, r_p_hi;
    logic [VOL_W-1:0]            r_vp;
    logic                        r_ovf;
    logic [SUM_W-1:0]            r_sum;

    logic [VOL_W-1:0]            r_res_volume;
    logic                        r_res_sat;
    logic [DIST_W-1:0]           r_res_dist;

    logic                        r_out_valid;
    logic [VOL_W-1:0]            r_out_volume;
    logic                        r_out_sat;
    logic [DIST_W-1:0]           r_out_dist;

    // ---------------------------------------------------------------- wires
    logic                        w_accept;
    logic                        w_last;
    logic                        w_out_free;
    logic signed [COORD_W-1:0]   w_in_lo, w_in_hi;
    logic signed [COORD_W-1:0]   w_lb, w_ub, w_nl, w_nu;
    logic signed [COORD_W:0]     w_diff;
    logic [EXT_W-1:0]            w_ext;
    logic                        w_wr_en;
    logic [2*COORD_W-1:0]        w_wr_data;
    logic [MUL_A_W-1:0]          w_mul_a;
    logic [MUL_P_W-1:0]          w_mul_p;
    logic [MUL_P_W-1:0]          w_upper;
    logic                        w_prod_ovf;
    logic [VOL_W-1:0]            w_vp_new;
    logic                        w_ovf_new;
    logic [SUM_W-1:0]            w_sum_new;
    logic                        w_is_vol;
    logic                        w_sqrt_start;
    logic [DIST_W-1:0]           w_sqrt_root;
    t_sqrt_stat                  w_sqrt_stat;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_last     = (r_dim == DIM_W'(DIMS - 1));
    assign w_out_free = !r_out_valid || !i_out_stall;

    // order the incoming interval so lower never exceeds upper
    assign w_in_lo = (i_low_coord > i_high_coord) ? i_high_coord : i_low_coord;
    assign w_in_hi = (i_low_coord > i_high_coord) ? i_low_coord : i_high_coord;

    always_comb begin
        case (r_run_kind) inside
            K_SET, K_EXTEND, K_ENLARGE, K_VOLUME: w_is_vol = 1'b1;
            default:                              w_is_vol = 1'b0;
        endcase
    end

    // ---------------------------------------------------------------- compare stage
    always_comb begin
        w_lb      = r_rd_vld ? $signed(r_rd_data[2*COORD_W-1:COORD_W]) : '0;
        w_ub      = r_rd_vld ? $signed(r_rd_data[COORD_W-1:0])         : '0;
        w_nl      = (w_lb < r_lo) ? w_lb : r_lo;
        w_nu      = (w_ub > r_hi) ? w_ub : r_hi;
        w_diff    = '0;
        w_wr_en   = 1'b0;
        w_wr_data = {w_nl, w_nu};
        case (r_run_kind)
            K_SET: begin
                w_wr_en   = 1'b1;
                w_wr_data = {r_lo, r_hi};
                w_diff    = {r_hi[COORD_W-1], r_hi} - {r_lo[COORD_W-1], r_lo};
            end
            K_EXTEND: begin
                w_wr_en = 1'b1;
                w_diff  = {w_nu[COORD_W-1], w_nu} - {w_nl[COORD_W-1], w_nl};
            end
            K_ENLARGE: begin
                w_diff = {w_nu[COORD_W-1], w_nu} - {w_nl[COORD_W-1], w_nl};
            end
            K_VOLUME: begin
                w_diff = {w_ub[COORD_W-1], w_ub} - {w_lb[COORD_W-1], w_lb};
            end
            K_DIST: begin
                // gap from the point to the interval, zero inside
                if (r_pt < w_lb) begin
                    w_diff = {w_lb[COORD_W-1], w_lb} - {r_pt[COORD_W-1], r_pt};
                end else if (r_pt > w_ub) begin
                    w_diff = {r_pt[COORD_W-1], r_pt} - {w_ub[COORD_W-1], w_ub};
                end else begin
                    w_diff = '0;
                end
            end
            default: begin
                w_diff = '0;
            end
        endcase
        w_ext = w_diff[EXT_W-1:0];
    end

    // ---------------------------------------------------------------- shared multiplier
    always_comb begin
        if (r_state == S_MUL_HI) begin
            w_mul_a = MUL_A_W'(r_vp[VOL_W-1:MUL_A_W]);
        end else if (r_run_kind == K_DIST) begin
            w_mul_a = MUL_A_W'(r_ext);
        end else begin
            w_mul_a = r_vp[MUL_A_W-1:0];
        end
        w_mul_p = MUL_P_W'(w_mul_a) * MUL_P_W'(r_ext);
    end

    // ---------------------------------------------------------------- accumulate stage
    always_comb begin
        w_upper    = r_p_hi + MUL_P_W'(r_p_lo[MUL_P_W-1:MUL_A_W]);
        w_prod_ovf = |w_upper[MUL_P_W-1:VOL_W-MUL_A_W];
        w_sum_new  = r_sum + SUM_W'(r_p_lo[MUL_A_W-1:0]);
        if (r_zero_ext) begin
            // a zero factor makes the true product zero
            w_vp_new  = '0;
            w_ovf_new = 1'b0;
        end else if (w_prod_ovf) begin
            w_vp_new  = VOL_MAX;
            w_ovf_new = 1'b1;
        end else begin
            w_vp_new  = {w_upper[VOL_W-MUL_A_W-1:0], r_p_lo[MUL_A_W-1:0]};
            w_ovf_new = r_ovf;
        end
    end

    assign w_sqrt_start = (r_state == S_ACC) && w_last && (r_run_kind == K_DIST);

    bbv_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sqrt_start),
        .i_radicand (w_sum_new),
        .o_root     (w_sqrt_root),
        .o_stat     (w_sqrt_stat)
    );

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (w_accept) n_state = S_CALC;
            S_CALC:   n_state = S_MUL_LO;
            S_MUL_LO: n_state = (r_run_kind == K_DIST) ? S_ACC : S_MUL_HI;
            S_MUL_HI: n_state = S_ACC;
            S_ACC: begin
                if (!w_last) begin
                    n_state = S_IDLE;
                end else if (w_is_vol) begin
                    n_state = S_OUT;
                end else if (r_run_kind == K_DIST) begin
                    n_state = S_SQRT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SQRT:   if (w_sqrt_stat.done) n_state = S_OUT;
            S_OUT:    if (w_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // run control: dimension counter, product, overflow flag, gap sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim <= '0;
            r_vp  <= VOL_W'(1);
            r_ovf <= 1'b0;
            r_sum <= '0;
        end else if (r_state == S_ACC) begin
            if (w_last) begin
                // drop the run state; the result is held separately
                r_dim <= '0;
                r_vp  <= VOL_W'(1);
                r_ovf <= 1'b0;
                r_sum <= '0;
            end else begin
                r_dim <= r_dim + 1'b1;
                if (w_is_vol) begin
                    r_vp  <= w_vp_new;
                    r_ovf <= w_ovf_new;
                end else if (r_run_kind == K_DIST) begin
                    r_sum <= w_sum_new;
                end
            end
        end
    end

    // request capture and datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            if (r_dim == '0) begin
                r_run_kind <= t_kind'(i_kind);
            end
            r_lo      <= w_in_lo;
            r_hi      <= w_in_hi;
            r_pt      <= i_low_coord;
            r_rd_data <= r_bounds_mem[r_dim];
            r_rd_vld  <= r_bounds_vld[r_dim];
        end
        if (r_state == S_CALC) begin
            r_ext      <= w_ext;
            r_zero_ext <= (w_ext == '0);
        end
        if (r_state == S_MUL_LO) begin
            r_p_lo <= w_mul_p;
        end
        if (r_state == S_MUL_HI) begin
            r_p_hi <= w_mul_p;
        end
        if ((r_state == S_ACC) && w_last) begin
            r_res_volume <= w_is_vol ? w_vp_new  : '0;
            r_res_sat    <= w_is_vol ? w_ovf_new : 1'b0;
            r_res_dist   <= '0;
        end
        if ((r_state == S_SQRT) && w_sqrt_stat.done) begin
            r_res_dist <= w_sqrt_root;
        end
    end

    // write back updated bounds
    always_ff @(posedge i_clk) begin
        if ((r_state == S_CALC) && w_wr_en) begin
            r_bounds_mem[r_dim] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bounds_vld <= '0;
        end else if ((r_state == S_CALC) && w_wr_en) begin
            r_bounds_vld[r_dim] <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_OUT) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (w_out_free) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && w_out_free) begin
            r_out_volume <= r_res_volume;
            r_out_sat    <= r_res_sat;
            r_out_dist   <= r_res_dist;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_volume           = r_out_volume;
    assign o_volume_saturated = r_out_sat;
    assign o_distance         = r_out_dist;

    // ---------------------------------------------------------------- checks
    a_ovf_means_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_vp == VOL_MAX))
        else $error("overflow flag set without a saturated product");

    a_sat_result_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_volume_saturated) |-> (o_volume == VOL_MAX))
        else $error("saturated result without maximum volume");

    a_dist_no_volume: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_distance != '0)) |-> ((o_volume == '0) && !o_volume_saturated))
        else $error("distance result carries a volume");

    a_accept_to_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_CALC))
        else $error("accepted request did not advance to the compare stage");

    a_sqrt_alive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT) |-> (w_sqrt_stat.busy || w_sqrt_stat.done))
        else $error("waiting on an idle square root unit");

endmodule

/* verif/bounding_box_volume_and_mindist_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for bounding_box_volume_and_mindist: directed and random
// box runs under several idle/stall mixes, checked against an in-bench box predictor.
// Depends on bbv_pkg and the block's RTL.
module bounding_box_volume_and_mindist_tb;

    import bbv_pkg::*;

    // Run shape.
    localparam int RUNS_PER_PHASE = 118;   // four items per run
    localparam int HOLDOFF_RUNS   = 12;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 60;    // covers a distance run plus the square root
    localparam int MAX_REPORTS    = 10;
    localparam int LIMIT_NS       = 1500000;

    // Kinds above K_DIST are reserved: a run of them consumes items and yields nothing.
    localparam logic [KIND_W-1:0] K_RESERVED = 3'd7;

    typedef struct packed {
        logic [VOL_W-1:0]  volume;
        logic              saturated;
        logic [DIST_W-1:0] distance;
    } t_box_result;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic [KIND_W-1:0]         i_kind = '0;
    logic signed [COORD_W-1:0] i_low_coord = '0;
    logic signed [COORD_W-1:0] i_high_coord = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic [VOL_W-1:0]          o_volume;
    logic                      o_volume_saturated;
    logic [DIST_W-1:0]         o_distance;

    bounding_box_volume_and_mindist dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_kind             (i_kind),
        .i_low_coord        (i_low_coord),
        .i_high_coord       (i_high_coord),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_volume           (o_volume),
        .o_volume_saturated (o_volume_saturated),
        .o_distance         (o_distance)
    );

    // ------------------------------------------------------------------
    // Predictor state: the box, the run in progress and its accumulators.
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] box_lo [DIMS];
    logic signed [COORD_W-1:0] box_hi [DIMS];
    int                        run_dim = 0;
    logic [KIND_W-1:0]         run_op = K_SET;
    logic [VOL_W-1:0]          running_volume = VOL_W'(1);
    logic                      volume_clipped = 1'b0;
    logic [SUM_W-1:0]          gap_square_sum = '0;

    t_box_result expected_results [$];

    // Idle and stall mix of the current phase, in percent.
    int send_idle_pct = 0;
    int stall_pct     = 0;

    logic holding_off = 1'b0;
    event holdoff_start;

    int requests_sent     = 0;
    int results_checked   = 0;
    int volume_results    = 0;
    int distance_results  = 0;
    int saturated_results = 0;
    int mismatch_count    = 0;

    // Free-running clock, 2 ns period.
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Give up after a generous fixed time; a hang is a failure.
    initial begin
        #(LIMIT_NS);
        $display("Timed out with %0d results still awaited", expected_results.size());
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Multiply the running volume by one extent, clipping at the top of the range.
    // A zero extent gives a true product of zero, so drop the clip flag too.
    task automatic scale_volume(input logic [EXT_W-1:0] ext);
        logic [VOL_W+EXT_W-1:0] wide;
        if (ext == '0) begin
            running_volume = '0;
            volume_clipped = 1'b0;
        end else begin
            wide = {{EXT_W{1'b0}}, running_volume} * {{VOL_W{1'b0}}, ext};
            if (wide > {{EXT_W{1'b0}}, VOL_MAX}) begin
                running_volume = VOL_MAX;
                volume_clipped = 1'b1;
            end else begin
                running_volume = wide[VOL_W-1:0];
            end
        end
    endtask

    // Floor square root, one result bit at a time from the top.
    function automatic logic [DIST_W-1:0] floor_root(input logic [SUM_W-1:0] x);
        logic [DIST_W-1:0] root;
        logic [DIST_W-1:0] trial;
        root = '0;
        for (int b = DIST_W - 1; b >= 0; b--) begin
            trial = root | (DIST_W'(1) << b);
            if ({{DIST_W{1'b0}}, trial} * {{DIST_W{1'b0}}, trial} <= x)
                root = trial;
        end
        return root;
    endfunction

    // Advance the box by one accepted request and queue the result it completes.
    task automatic box_step(input logic [KIND_W-1:0] kind_in,
                            input logic [COORD_W-1:0] lo_in,
                            input logic [COORD_W-1:0] hi_in);
        logic signed [COORD_W:0] lo, hi, swap, new_lo, new_hi, point, gap;
        t_box_result want;
        int d;
        d = run_dim;
        // The kind counts only on the first dimension of a run.
        if (run_dim == 0)
            run_op = kind_in;
        lo = {lo_in[COORD_W-1], lo_in};
        hi = {hi_in[COORD_W-1], hi_in};
        // Reversed interval: swap so the lower bound never exceeds the upper.
        if (lo > hi) begin
            swap = lo;
            lo   = hi;
            hi   = swap;
        end
        case (run_op)
            K_SET: begin
                box_lo[d] = lo[COORD_W-1:0];
                box_hi[d] = hi[COORD_W-1:0];
                scale_volume(EXT_W'(hi - lo));
            end
            K_EXTEND, K_ENLARGE: begin
                new_lo = (box_lo[d] < lo) ? box_lo[d] : lo;
                new_hi = (box_hi[d] > hi) ? box_hi[d] : hi;
                // Only an extend keeps the grown box; the enlarge query discards it.
                if (run_op == K_EXTEND) begin
                    box_lo[d] = new_lo[COORD_W-1:0];
                    box_hi[d] = new_hi[COORD_W-1:0];
                end
                scale_volume(EXT_W'(new_hi - new_lo));
            end
            K_VOLUME: begin
                scale_volume(EXT_W'(box_hi[d] - box_lo[d]));
            end
            K_DIST: begin
                // Point distance uses the low coordinate as given, before any swap.
                point = {lo_in[COORD_W-1], lo_in};
                if (point < box_lo[d])
                    gap = box_lo[d] - point;
                else if (point > box_hi[d])
                    gap = point - box_hi[d];
                else
                    gap = '0;
                gap_square_sum = gap_square_sum
                               + SUM_W'(gap[COORD_W-1:0]) * SUM_W'(gap[COORD_W-1:0]);
            end
            default: ;
        endcase

        if (d == DIMS - 1) begin
            if (run_op < K_DIST) begin
                want.volume    = running_volume;
                want.saturated = volume_clipped;
                want.distance  = '0;
                expected_results.insert(expected_results.size(), want);
            end else if (run_op == K_DIST) begin
                want.volume    = '0;
                want.saturated = 1'b0;
                want.distance  = floor_root(gap_square_sum);
                expected_results.insert(expected_results.size(), want);
            end
            run_dim        = 0;
            running_volume = VOL_W'(1);
            volume_clipped = 1'b0;
            gap_square_sum = '0;
        end else begin
            run_dim = d + 1;
        end
    endtask

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offer one request and hold it until the block takes it. Called at a rising
    // edge; returns at the edge that accepted it, with valid still high.
    task automatic send_request(input logic [KIND_W-1:0] kind_in,
                                input logic [COORD_W-1:0] lo_in,
                                input logic [COORD_W-1:0] hi_in);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_kind       <= kind_in;
        i_low_coord  <= lo_in;
        i_high_coord <= hi_in;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        requests_sent++;
        box_step(kind_in, lo_in, hi_in);
    endtask

    // One whole run; coordinates packed with dimension 0 in the low bits.
    task automatic send_run(input logic [KIND_W-1:0] kind_in,
                            input logic [DIMS*COORD_W-1:0] lo_all,
                            input logic [DIMS*COORD_W-1:0] hi_all);
        for (int d = 0; d < DIMS; d++)
            send_request(kind_in, lo_all[d*COORD_W +: COORD_W], hi_all[d*COORD_W +: COORD_W]);
    endtask

    // Coordinate mix: the range ends, small values around zero, values close to
    // the current bounds of this dimension, and anything at all.
    function automatic logic [COORD_W-1:0] pick_coord(input int d);
        int sel;
        sel = $urandom_range(9);
        case (sel)
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2, 3, 4: return COORD_W'($urandom_range(80)) - 16'd40;
            5, 6:    return box_lo[d] + COORD_W'($urandom_range(80)) - 16'd40;
            7:       return box_hi[d] + COORD_W'($urandom_range(80)) - 16'd40;
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function automatic logic [KIND_W-1:0] pick_kind();
        int sel;
        sel = $urandom_range(99);
        if (sel < 20)      return K_SET;
        else if (sel < 35) return K_EXTEND;
        else if (sel < 50) return K_ENLARGE;
        else if (sel < 62) return K_VOLUME;
        else if (sel < 90) return K_DIST;
        else               return K_DIST + KIND_W'($urandom_range(1, 3));
    endfunction

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Stall the result channel at the phase's rate, or solidly during a hold-off.
    always @(posedge i_clk)
        i_out_stall <= holding_off || ($urandom_range(99) < stall_pct);

    // Hold off the result channel for a fixed count of cycles on request.
    initial begin
        forever begin
            @(holdoff_start);
            holding_off <= 1'b1;
            repeat (HOLDOFF_CYCLES) @(posedge i_clk);
            holding_off <= 1'b0;
        end
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    // Compare every accepted result with the oldest outstanding prediction.
    always @(posedge i_clk) begin : check_results
        t_box_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result volume=%0d sat=%0b dist=%0d",
                                          o_volume, o_volume_saturated, o_distance));
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (want.distance != '0 || (want.volume == '0 && !want.saturated
                                            && o_distance != '0))
                    distance_results++;
                else
                    volume_results++;
                if (want.saturated)
                    saturated_results++;
                if (o_volume !== want.volume || o_volume_saturated !== want.saturated
                        || o_distance !== want.distance)
                    report_mismatch($sformatf(
                        "expected volume=%0d sat=%0b dist=%0d, got volume=%0d sat=%0b dist=%0d",
                        want.volume, want.saturated, want.distance,
                        o_volume, o_volume_saturated, o_distance));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked runs: range ends, reversed intervals, a zero extent, saturation,
    // each operation, a point with a junk high coordinate and a reserved kind.
    task automatic test_directed_cases();
        send_idle_pct = 0;
        stall_pct     = 0;
        // Full-range box, two dimensions given reversed: the product saturates.
        send_run(K_SET, {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000},
                        {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
        // Current volume; coordinates are ignored.
        send_run(K_VOLUME, {16'h1234, 16'hFFFF, 16'h0000, 16'h8001},
                           {16'hABCD, 16'h0001, 16'h7FFE, 16'h0000});
        // Small box with a reversed interval and a zero extent in the last dimension.
        send_run(K_SET, {16'h0005, 16'h0000, 16'hFFFF, 16'h000A},
                        {16'h0005, 16'h0007, 16'h0002, 16'hFFFD});
        // Grow on one side, the other, not at all, and to the full range.
        send_run(K_EXTEND, {16'h7FFF, 16'h0003, 16'h0064, 16'hFFEC},
                           {16'h8000, 16'h0004, 16'h005A, 16'hFFEC});
        // Enlarged volume near the top of the range; the box must stay unchanged.
        send_run(K_ENLARGE, {16'h0000, 16'h8000, 16'h7FFF, 16'h8000},
                            {16'h0000, 16'h7FFF, 16'h7FFF, 16'h8000});
        // Point below, inside, above and inside; high coordinates are junk.
        send_run(K_DIST, {16'h0000, 16'h7FFF, 16'h0032, 16'h8000},
                         {16'h8000, 16'h0000, 16'h7FFF, 16'h1111});
        // Reserved kind: consumes a run, touches nothing, yields nothing.
        send_run(K_RESERVED, {16'h0100, 16'h8000, 16'h7FFF, 16'h0000},
                             {16'hFF00, 16'h7FFF, 16'h8000, 16'h0000});
    endtask

    // Random runs under one idle/stall mix. Only the first item's kind selects the
    // operation, so scramble the kind on the rest.
    task automatic test_random_runs(input int runs, input int idle_pct, input int hold_pct);
        logic [KIND_W-1:0] op;
        send_idle_pct = idle_pct;
        stall_pct     = hold_pct;
        for (int r = 0; r < runs; r++) begin
            op = pick_kind();
            for (int d = 0; d < DIMS; d++)
                send_request((d == 0) ? op : KIND_W'($urandom_range(7)),
                             pick_coord(d), pick_coord(d));
        end
    endtask

    // Hold the result channel off for a long stretch while requests keep coming,
    // so the output register fills and the block stalls its input.
    task automatic test_output_holdoff();
        logic [KIND_W-1:0] op;
        send_idle_pct = 0;
        stall_pct     = 0;
        -> holdoff_start;
        for (int r = 0; r < HOLDOFF_RUNS; r++) begin
            op = (r % 2 == 0) ? K_DIST : KIND_W'($urandom_range(3));
            for (int d = 0; d < DIMS; d++)
                send_request(op, pick_coord(d), pick_coord(d));
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        for (int d = 0; d < DIMS; d++) begin
            box_lo[d] = '0;
            box_hi[d] = '0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_random_runs(RUNS_PER_PHASE, 0, 0);
        test_random_runs(RUNS_PER_PHASE, 53, 0);
        test_random_runs(RUNS_PER_PHASE, 0, 53);
        test_random_runs(RUNS_PER_PHASE, 17, 17);
        test_output_holdoff();

        // Drop valid, wait for every outstanding result, then watch for strays.
        i_in_valid <= 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests: set, extend, enlarge, volume, distance and reserved runs",
                 requests_sent);
        $display("Checked %0d results (%0d volume, %0d distance, %0d saturated), %0d mismatches",
                 results_checked, volume_results, distance_results, saturated_results,
                 mismatch_count);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* bounding_box_volume_and_mindist.f */
design/bbv_pkg.sv
design/bbv_isqrt.sv
design/bounding_box_volume_and_mindist.sv
verif/bounding_box_volume_and_mindist_tb.sv
